// ===== rtl/etoq_pkg.sv =====
// shared types, constants and address helpers for the event time ordered queue
`default_nettype none
package etoq_pkg;

   // storage geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW          = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_CW      = 7;

   // field widths
   localparam int DATE_W  = 48;
   localparam int RANK_W  = 32;
   localparam int BLOCK_W = 16;
   localparam int TAG_W   = 16;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   // register indexes
   localparam logic REG_QUEUE_MODE = 1'b0;
   localparam logic REG_MAX_DATE   = 1'b1;

   // queue mode codes
   localparam logic MODE_REALTIME      = 1'b0;
   localparam logic MODE_DETERMINISTIC = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOT_DUE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_PLACE,
      S_POPCHK
   } state_type;

   typedef struct packed {
      logic [DATE_W-1:0]  date;
      logic [RANK_W-1:0]  rank;
      logic [BLOCK_W-1:0] block;
      logic [TAG_W-1:0]   tag;
   } entry_type;

   typedef struct packed {
      logic stop;
      logic sub_set;
   } scan_res_type;

   typedef struct packed {
      status_type         status;
      logic               popped_valid;
      logic [DATE_W-1:0]  date;
      logic [TAG_W-1:0]   tag;
      logic [BLOCK_W-1:0] block;
      logic               past_limit;
      logic [OUT_CW-1:0]  queue_count;
      logic [OUT_CW-1:0]  peak_count;
   } resp_type;

   // logical slot to physical slot in the circular store
   function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] offs);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (AW+1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/etoq_store.sv =====
// entry store: one write port, one registered read port
`default_nettype none
module etoq_store (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [etoq_pkg::AW-1:0] wr_addr,
   input  wire etoq_pkg::entry_type   wr_data,
   input  wire logic [etoq_pkg::AW-1:0] rd_addr,
   output etoq_pkg::entry_type        rd_data
);

   etoq_pkg::entry_type mem [etoq_pkg::QUEUE_DEPTH];
   etoq_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/etoq_cmp.sv =====
// ordering compare unit: decides whether the insert scan stops at one entry
`default_nettype none
module etoq_cmp (
   input  wire etoq_pkg::entry_type     entry,
   input  wire etoq_pkg::entry_type     key,
   input  wire logic                    mode,
   input  wire logic                    sub_scan,
   output etoq_pkg::scan_res_type       res
);

   logic date_lt;
   logic date_eq;
   logic rank_eq;
   logic rank_gt;
   logic block_gt;

   assign date_lt  = entry.date < key.date;
   assign date_eq  = entry.date == key.date;
   assign rank_eq  = entry.rank == key.rank;
   assign rank_gt  = entry.rank > key.rank;
   assign block_gt = entry.block > key.block;

   // stop decision over the date run and the rank / block id tie-break
   always_comb begin
      res.stop    = 1'b0;
      res.sub_set = 1'b0;
      priority if (date_lt) begin
         res.stop = 1'b0;
      end else if (!date_eq) begin
         res.stop = 1'b1;
      end else if (mode == etoq_pkg::MODE_REALTIME) begin
         res.stop = 1'b0;
      end else if (sub_scan) begin
         res.stop = !(rank_eq && !block_gt);
      end else if (entry.rank == '0) begin
         res.stop = 1'b0;
      end else if (rank_gt) begin
         res.stop = 1'b1;
      end else if (rank_eq) begin
         res.stop    = block_gt;
         res.sub_set = !block_gt;
      end else begin
         res.stop = 1'b0;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/event_time_ordered_queue.sv =====
// event time ordered queue: sequencer, circular store and ordering compare
// insert: one store read per scanned slot, then one read and write per moved slot, then
//    the new entry is written in S_PLACE; reject of a full insert or a pop on an empty
//    queue answers in the cycle after start; other pops answer through the S_POPCHK state
// throughput: one command at a time, start is taken again once busy is low
// reset: queue empty, peak zero, realtime mode, max_date all ones; no clearing pass
// the result strobe lasts one cycle and cannot be held off by the receiver
`default_nettype none
module event_time_ordered_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_cmd,
   input  wire logic [etoq_pkg::DATE_W-1:0] req_event_date,
   input  wire logic [etoq_pkg::RANK_W-1:0] req_tie_rank,
   input  wire logic [etoq_pkg::BLOCK_W-1:0] req_block_id,
   input  wire logic [etoq_pkg::TAG_W-1:0]  req_event_tag,
   input  wire logic [etoq_pkg::DATE_W-1:0] req_now_time,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_popped_valid,
   output logic [etoq_pkg::DATE_W-1:0]      rsp_out_date,
   output logic [etoq_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic [etoq_pkg::BLOCK_W-1:0]     rsp_out_block,
   output logic                             rsp_past_limit,
   output logic [etoq_pkg::OUT_CW-1:0]      rsp_queue_count,
   output logic [etoq_pkg::OUT_CW-1:0]      rsp_peak_count,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [etoq_pkg::DATE_W-1:0] csr_wr_data
);

   etoq_pkg::state_type     state_ff, state_in;
   logic [etoq_pkg::AW-1:0] head_ff, head_in;
   logic [etoq_pkg::CW-1:0] count_ff, count_in;
   logic [etoq_pkg::CW-1:0] peak_ff, peak_in;
   logic [etoq_pkg::AW-1:0] idx_ff, idx_in;
   logic [etoq_pkg::AW-1:0] pos_ff, pos_in;
   logic                    sub_ff, sub_in;
   etoq_pkg::entry_type     key_ff, key_in;
   logic [etoq_pkg::DATE_W-1:0] now_ff, now_in;
   logic                    mode_ff;
   logic [etoq_pkg::DATE_W-1:0] max_date_ff;
   etoq_pkg::resp_type      rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [etoq_pkg::AW-1:0] rd_lidx;
   logic [etoq_pkg::AW-1:0] wr_lidx;
   logic                    wr_en;
   etoq_pkg::entry_type     wr_data;
   etoq_pkg::entry_type     rd_data;
   etoq_pkg::entry_type     req_entry;
   etoq_pkg::scan_res_type  scan_res;

   logic is_full;
   logic is_empty;
   logic scan_end;
   logic last_idx;
   logic not_due;
   logic [etoq_pkg::CW-1:0] count_inc;
   logic [etoq_pkg::CW-1:0] count_dec;
   logic [etoq_pkg::AW-1:0] tail_lidx;

   // entry store and compare unit
   etoq_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (etoq_pkg::phys_addr(head_ff, wr_lidx)),
      .wr_data (wr_data),
      .rd_addr (etoq_pkg::phys_addr(head_ff, rd_lidx)),
      .rd_data (rd_data)
   );

   etoq_cmp u_cmp (
      .entry    (rd_data),
      .key      (key_ff),
      .mode     (mode_ff),
      .sub_scan (sub_ff),
      .res      (scan_res)
   );

   // shared status flags
   assign req_entry = '{date: req_event_date, rank: req_tie_rank,
                        block: req_block_id, tag: req_event_tag};
   assign is_full   = count_ff == etoq_pkg::CW'(etoq_pkg::QUEUE_DEPTH);
   assign is_empty  = count_ff == '0;
   assign scan_end  = {1'b0, idx_ff} == (etoq_pkg::AW+1)'(count_ff);
   assign last_idx  = idx_ff == pos_ff;
   assign not_due   = (mode_ff == etoq_pkg::MODE_REALTIME) && (rd_data.date > now_ff);
   assign count_inc = count_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign tail_lidx = etoq_pkg::AW'(count_dec);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         etoq_pkg::S_IDLE: begin
            if (start) begin
               if (req_cmd == etoq_pkg::CMD_INSERT) begin
                  if (is_full) state_in = etoq_pkg::S_IDLE;
                  else if (is_empty) state_in = etoq_pkg::S_PLACE;
                  else state_in = etoq_pkg::S_SCAN;
               end else begin
                  state_in = is_empty ? etoq_pkg::S_IDLE : etoq_pkg::S_POPCHK;
               end
            end
         end
         etoq_pkg::S_SCAN: begin
            if (scan_end) state_in = etoq_pkg::S_PLACE;
            else if (scan_res.stop) state_in = etoq_pkg::S_SHIFT;
         end
         etoq_pkg::S_SHIFT: begin
            if (last_idx) state_in = etoq_pkg::S_PLACE;
         end
         etoq_pkg::S_PLACE:  state_in = etoq_pkg::S_IDLE;
         etoq_pkg::S_POPCHK: state_in = etoq_pkg::S_IDLE;
         default:            state_in = etoq_pkg::S_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      rd_lidx      = '0;
      wr_lidx      = '0;
      wr_en        = 1'b0;
      wr_data      = key_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      sub_in       = sub_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      peak_in      = peak_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         etoq_pkg::S_IDLE: begin
            if (start) begin
               key_in = req_entry;
               now_in = req_now_time;
               idx_in = '0;
               pos_in = '0;
               sub_in = 1'b0;
               rsp_in.popped_valid = 1'b0;
               rsp_in.date         = '0;
               rsp_in.tag          = '0;
               rsp_in.block        = '0;
               rsp_in.past_limit   = 1'b0;
               rsp_in.queue_count  = etoq_pkg::OUT_CW'(count_ff);
               rsp_in.peak_count   = etoq_pkg::OUT_CW'(peak_ff);
               if (req_cmd == etoq_pkg::CMD_INSERT) begin
                  rsp_in.status = etoq_pkg::ST_FULL;
                  rsp_valid_in  = is_full;
               end else begin
                  rsp_in.status = etoq_pkg::ST_EMPTY;
                  rsp_valid_in  = is_empty;
               end
            end
         end
         // forward scan, one entry a cycle
         etoq_pkg::S_SCAN: begin
            if (scan_end) begin
               pos_in = idx_ff;
            end else if (scan_res.stop) begin
               pos_in  = idx_ff;
               idx_in  = tail_lidx;
               rd_lidx = tail_lidx;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_lidx = idx_ff + 1'b1;
               sub_in  = sub_ff | scan_res.sub_set;
            end
         end
         // move entries up by one slot from the tail down to the insert point
         etoq_pkg::S_SHIFT: begin
            wr_en   = 1'b1;
            wr_lidx = idx_ff + 1'b1;
            wr_data = rd_data;
            if (!last_idx) begin
               idx_in  = idx_ff - 1'b1;
               rd_lidx = idx_ff - 1'b1;
            end
         end
         etoq_pkg::S_PLACE: begin
            wr_en    = 1'b1;
            wr_lidx  = pos_ff;
            count_in = count_inc;
            if (count_inc > peak_ff) peak_in = count_inc;
            rsp_valid_in       = 1'b1;
            rsp_in.status      = etoq_pkg::ST_OK;
            rsp_in.queue_count = etoq_pkg::OUT_CW'(count_inc);
            rsp_in.peak_count  = etoq_pkg::OUT_CW'((count_inc > peak_ff) ? count_inc : peak_ff);
         end
         etoq_pkg::S_POPCHK: begin
            rsp_valid_in = 1'b1;
            if (not_due) begin
               rsp_in.status = etoq_pkg::ST_NOT_DUE;
            end else begin
               rsp_in.status       = etoq_pkg::ST_OK;
               rsp_in.popped_valid = 1'b1;
               rsp_in.date         = rd_data.date;
               rsp_in.tag          = rd_data.tag;
               rsp_in.block        = rd_data.block;
               rsp_in.past_limit   = rd_data.date > max_date_ff;
               rsp_in.queue_count  = etoq_pkg::OUT_CW'(count_dec);
               head_in  = etoq_pkg::phys_addr(head_ff, etoq_pkg::AW'(1));
               count_in = count_dec;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etoq_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= etoq_pkg::MODE_REALTIME;
         max_date_ff  <= '1;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            if (csr_index == etoq_pkg::REG_QUEUE_MODE) mode_ff <= csr_wr_data[0];
            else max_date_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      sub_ff <= sub_in;
      key_ff <= key_in;
      now_ff <= now_in;
      rsp_ff <= rsp_in;
   end

   assign busy             = state_ff != etoq_pkg::S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_popped_valid = rsp_ff.popped_valid;
   assign rsp_out_date     = rsp_ff.date;
   assign rsp_out_tag      = rsp_ff.tag;
   assign rsp_out_block    = rsp_ff.block;
   assign rsp_past_limit   = rsp_ff.past_limit;
   assign rsp_queue_count  = rsp_ff.queue_count;
   assign rsp_peak_count   = rsp_ff.peak_count;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= etoq_pkg::CW'(etoq_pkg::QUEUE_DEPTH))
      else $error("held count above depth");

   a_peak_covers: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= count_ff)
      else $error("peak below held count");

   a_word_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result word while sequencer busy");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == etoq_pkg::S_POPCHK && !not_due) |=> count_ff == $past(count_dec))
      else $error("pop did not drop held count");

endmodule
`default_nettype wire

// ===== sim/etoq_checker.sv =====
// checker for the event time ordered queue: watches both channels, predicts and compares
`timescale 1ns / 1ps
`default_nettype none
module etoq_checker
   import etoq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire logic                  req_cmd,
   input  wire logic [DATE_W-1:0]     req_event_date,
   input  wire logic [RANK_W-1:0]     req_tie_rank,
   input  wire logic [BLOCK_W-1:0]    req_block_id,
   input  wire logic [TAG_W-1:0]      req_event_tag,
   input  wire logic [DATE_W-1:0]     req_now_time,
   input  wire logic                  rsp_valid,
   input  wire logic [1:0]            rsp_status,
   input  wire logic                  rsp_popped_valid,
   input  wire logic [DATE_W-1:0]     rsp_out_date,
   input  wire logic [TAG_W-1:0]      rsp_out_tag,
   input  wire logic [BLOCK_W-1:0]    rsp_out_block,
   input  wire logic                  rsp_past_limit,
   input  wire logic [OUT_CW-1:0]     rsp_queue_count,
   input  wire logic [OUT_CW-1:0]     rsp_peak_count,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_index,
   input  wire logic [DATE_W-1:0]     csr_wr_data,
   output int                         fail_count,
   output int                         pending_words,
   output int                         word_count,
   output int                         pop_count
);

   // predicted queue contents, head at index 0
   entry_type  sorted_q[$];
   resp_type   expected_q[$];
   logic       mode_r;
   logic [DATE_W-1:0] limit_r;
   int         peak_r;

   assign pending_words = expected_q.size();

   // placement of a new entry in the date order
   function automatic int place_index(entry_type e);
      int lo, hi, i;
      lo = 0;
      while (lo < sorted_q.size() && sorted_q[lo].date < e.date) lo++;
      hi = lo;
      while (hi < sorted_q.size() && sorted_q[hi].date == e.date) hi++;
      if (mode_r == MODE_REALTIME) return hi;
      i = lo;
      while (i < hi) begin
         if (sorted_q[i].rank == 0) begin
            i++;
         end else if (sorted_q[i].rank > e.rank) begin
            break;
         end else if (sorted_q[i].rank == e.rank) begin
            while (i < hi && sorted_q[i].rank == e.rank) begin
               if (sorted_q[i].block > e.block) break;
               i++;
            end
            break;
         end else begin
            i++;
         end
      end
      return i;
   endfunction

   // outcome of one accepted command word
   function automatic resp_type predict_word(logic cmd, entry_type e, logic [DATE_W-1:0] now);
      resp_type r;
      r = '0;
      r.status = ST_OK;
      if (cmd == CMD_INSERT) begin
         if (sorted_q.size() >= QUEUE_DEPTH) r.status = ST_FULL;
         else begin
            sorted_q.insert(place_index(e), e);
            if (sorted_q.size() > peak_r) peak_r = sorted_q.size();
         end
      end else if (sorted_q.size() == 0) begin
         r.status = ST_EMPTY;
      end else if (mode_r == MODE_REALTIME && sorted_q[0].date > now) begin
         r.status = ST_NOT_DUE;
      end else begin
         r.popped_valid = 1'b1;
         r.date = sorted_q[0].date;
         r.tag = sorted_q[0].tag;
         r.block = sorted_q[0].block;
         r.past_limit = sorted_q[0].date > limit_r;
         void'(sorted_q.pop_front());
      end
      r.queue_count = OUT_CW'(sorted_q.size());
      r.peak_count = OUT_CW'(peak_r);
      return r;
   endfunction

   always @(posedge clock) begin
      resp_type exp_w;
      entry_type e;
      if (reset) begin
         sorted_q.delete();
         expected_q.delete();
         mode_r <= MODE_REALTIME;
         limit_r <= '1;
         peak_r = 0;
         fail_count <= 0;
         word_count <= 0;
         pop_count <= 0;
      end else begin
         // register writes
         if (csr_wr_en) begin
            if (csr_index == REG_QUEUE_MODE) mode_r <= csr_wr_data[0];
            else limit_r <= csr_wr_data;
         end
         // result word compare
         if (rsp_valid) begin
            word_count <= word_count + 1;
            if (rsp_popped_valid) pop_count <= pop_count + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result word status=%0d", $time, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = expected_q.pop_front();
               if (rsp_status !== exp_w.status || rsp_popped_valid !== exp_w.popped_valid
                   || rsp_out_date !== exp_w.date || rsp_out_tag !== exp_w.tag
                   || rsp_out_block !== exp_w.block || rsp_past_limit !== exp_w.past_limit
                   || rsp_queue_count !== exp_w.queue_count
                   || rsp_peak_count !== exp_w.peak_count) begin
                  $display("%0t: mismatch expected st=%0d pv=%0d d=%h t=%h b=%h pl=%0d c=%0d p=%0d",
                           $time, exp_w.status, exp_w.popped_valid, exp_w.date, exp_w.tag,
                           exp_w.block, exp_w.past_limit, exp_w.queue_count, exp_w.peak_count);
                  $display("%0t:          actual   st=%0d pv=%0d d=%h t=%h b=%h pl=%0d c=%0d p=%0d",
                           $time, rsp_status, rsp_popped_valid, rsp_out_date, rsp_out_tag,
                           rsp_out_block, rsp_past_limit, rsp_queue_count, rsp_peak_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // accepted command word
         if (start && !busy) begin
            e.date = req_event_date;
            e.rank = req_tie_rank;
            e.block = req_block_id;
            e.tag = req_event_tag;
            expected_q.push_back(predict_word(req_cmd, e, req_now_time));
         end
      end
   end

endmodule
`default_nettype wire

// ===== sim/tb_event_time_ordered_queue.sv =====
// testbench top: stimulus for the event time ordered queue and the final verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_event_time_ordered_queue;
   import etoq_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_cmd = CMD_INSERT;
   logic [DATE_W-1:0]   req_event_date = '0;
   logic [RANK_W-1:0]   req_tie_rank = '0;
   logic [BLOCK_W-1:0]  req_block_id = '0;
   logic [TAG_W-1:0]    req_event_tag = '0;
   logic [DATE_W-1:0]   req_now_time = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic                rsp_popped_valid;
   logic [DATE_W-1:0]   rsp_out_date;
   logic [TAG_W-1:0]    rsp_out_tag;
   logic [BLOCK_W-1:0]  rsp_out_block;
   logic                rsp_past_limit;
   logic [OUT_CW-1:0]   rsp_queue_count;
   logic [OUT_CW-1:0]   rsp_peak_count;
   logic                csr_wr_en = 1'b0;
   logic                csr_index = REG_QUEUE_MODE;
   logic [DATE_W-1:0]   csr_wr_data = '0;
   int                  fail_count, pending_words, word_count, pop_count;
   int                  sent_words = 0;
   bit                  idle_on = 1'b1;
   logic [DATE_W-1:0]   date_base;

   always #5 clock = ~clock;

   event_time_ordered_queue u_top (.*);

   etoq_checker u_checker (.*);

   // one command word, held until accepted; start stays high until the next word or a drop
   task automatic send_word(logic cmd, logic [DATE_W-1:0] d, logic [RANK_W-1:0] r,
                            logic [BLOCK_W-1:0] b, logic [TAG_W-1:0] t,
                            logic [DATE_W-1:0] now);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_event_date <= d;
      req_tie_rank <= r;
      req_block_id <= b;
      req_event_tag <= t;
      req_now_time <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_words++;
   endtask

   // release start after the last accepted word
   task automatic drop_start();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // register write while idle
   task automatic write_reg(logic idx, logic [DATE_W-1:0] v);
      drop_start();
      while (pending_words != 0) @(negedge clock);
      repeat (70) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random field values, dates clustered so equal-date runs are common
   function automatic logic [DATE_W-1:0] pick_date();
      case ($urandom_range(0, 7))
         0: return DATE_W'({$urandom, $urandom});
         1: return '1;
         default: return date_base + $urandom_range(0, 5);
      endcase
   endfunction

   function automatic logic [RANK_W-1:0] pick_rank();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom;
         2: return '1;
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   task automatic random_phase(int n, int pop_pct);
      logic [BLOCK_W-1:0] b;
      for (int i = 0; i < n; i++) begin
         b = ($urandom_range(0, 1)) ? BLOCK_W'($urandom_range(0, 3)) : BLOCK_W'($urandom);
         if ($urandom_range(0, 99) < pop_pct)
            send_word(CMD_POP, DATE_W'({$urandom, $urandom}), $urandom,
                      BLOCK_W'($urandom), TAG_W'($urandom),
                      ($urandom_range(0, 1)) ? date_base + $urandom_range(0, 5)
                                             : DATE_W'({$urandom, $urandom}));
         else
            send_word(CMD_INSERT, pick_date(), pick_rank(), b, TAG_W'($urandom), '0);
      end
   endtask

   initial begin
      date_base = 48'h0000_1000_0000;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, extremes, ties, not-due head, limit flag
      send_word(CMD_POP, '0, '0, '0, '0, '0);
      send_word(CMD_INSERT, '1, '1, '1, '1, '0);
      send_word(CMD_INSERT, '0, '0, '0, '0, '0);
      send_word(CMD_INSERT, 48'd5, 32'd0, 16'd9, 16'h11, '0);
      send_word(CMD_INSERT, 48'd5, 32'd2, 16'd4, 16'h12, '0);
      send_word(CMD_POP, '0, '0, '0, '0, '0);
      send_word(CMD_POP, '0, '0, '0, '0, 48'd4);
      send_word(CMD_POP, '0, '0, '0, '0, '1);
      write_reg(REG_QUEUE_MODE, MODE_DETERMINISTIC);
      write_reg(REG_MAX_DATE, '0);
      send_word(CMD_INSERT, 48'd5, 32'd2, 16'd7, 16'h21, '0);
      send_word(CMD_INSERT, 48'd5, 32'd2, 16'd3, 16'h22, '0);
      send_word(CMD_INSERT, 48'd5, 32'd1, 16'd3, 16'h23, '0);
      send_word(CMD_INSERT, 48'd5, 32'd0, 16'd3, 16'h24, '0);
      send_word(CMD_INSERT, 48'd5, 32'd3, 16'd0, 16'h25, '0);
      send_word(CMD_INSERT, 48'd5, 32'd2, 16'd7, 16'h26, '0);
      repeat (8) send_word(CMD_POP, '0, '0, '0, '0, '0);
      // fill past capacity to hit the full reject
      for (int i = 0; i < QUEUE_DEPTH + 2; i++)
         send_word(CMD_INSERT, pick_date(), pick_rank(), BLOCK_W'($urandom),
                   TAG_W'($urandom), '0);
      random_phase(70, 100);

      // random phases across both modes and limit settings
      write_reg(REG_MAX_DATE, date_base + 2);
      random_phase(150, 40);
      write_reg(REG_QUEUE_MODE, MODE_REALTIME);
      random_phase(150, 45);
      write_reg(REG_MAX_DATE, '1);
      write_reg(REG_QUEUE_MODE, MODE_DETERMINISTIC);
      random_phase(100, 50);
      idle_on = 1'b0;
      random_phase(60, 50);

      drop_start();
      while (pending_words != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      $display("run covered %0d command words, %0d result words, %0d pops with an entry",
               sent_words, word_count, pop_count);
      if (fail_count == 0 && pending_words == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
